FILE: hdl/integer_to_ascii_radix_defines.svh
// Assertion helpers shared by the converter RTL.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ITAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer_to_ascii_radix: implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ITAR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer_to_ascii_radix: next-cycle check failed");

`endif

FILE: hdl/itoa_pkg.sv
package itoa_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZERO,
    S_SIGN,
    S_DEC,
    S_SHIFT
  } state_t;

  // radix modes
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_OCT  = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ALPHA = 8'h57;  // 'a' minus ten

  localparam logic [3:0] LAST_POW   = 4'd9;   // index of the ones place
  localparam logic [3:0] HEX_DIGITS = 4'd8;
  localparam logic [3:0] OCT_DIGITS = 4'd11;

  function automatic logic [31:0] dec_power(input logic [3:0] idx);
    logic [31:0] p;
    begin
      unique case (idx)
        4'd0:    p = 32'd1000000000;
        4'd1:    p = 32'd100000000;
        4'd2:    p = 32'd10000000;
        4'd3:    p = 32'd1000000;
        4'd4:    p = 32'd100000;
        4'd5:    p = 32'd10000;
        4'd6:    p = 32'd1000;
        4'd7:    p = 32'd100;
        4'd8:    p = 32'd10;
        default: p = 32'd1;
      endcase
      return p;
    end
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    begin
      if (d < 4'd10) begin
        c = CHAR_ZERO + {4'b0, d};
      end else begin
        c = CHAR_ALPHA + {4'b0, d};
      end
      return c;
    end
  endfunction

endpackage

FILE: hdl/integer_to_ascii_radix.sv
// integer_to_ascii_radix: converts one 32-bit number per input transaction into a run of
// ASCII characters on the output channel, most significant digit first, leading zeros
// dropped, with last set on the final character. operation picks the radix: 0 signed
// decimal ('-' then the magnitude for negative values, the most negative value included),
// 1 unsigned decimal, 2 lowercase hex, 3 octal. A zero value gives the single character '0'.
// One transaction is taken at a time; in_ready is high only while the converter is idle,
// and a result held in the output register does not block the next input. Hex and octal
// step through 8 and 11 digit positions. Decimal runs through a single 32-bit
// subtract-and-compare unit that removes powers of ten one at a time, place by place from
// billions to ones, after a minus sign for negative signed values. Back-pressure on the
// output holds the sequencer while it has a character to emit.

`include "integer_to_ascii_radix_defines.svh"

module integer_to_ascii_radix (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic        last
);

  import itoa_pkg::*;

  state_t state, state_next;

  // conversion datapath
  logic [31:0] mag;       // decimal magnitude, reduced in place
  logic [3:0]  digit;     // count of subtractions for the current place
  logic [3:0]  pow_idx;   // current decimal place, 0 = billions
  logic        started;   // a nonzero digit has been emitted
  logic [32:0] sreg;      // hex/octal shift register, digit sits at the top
  logic [3:0]  cnt;       // hex/octal digits still to go
  logic        is_hex;

  logic        accept;
  logic [31:0] pow;
  logic [32:0] sub_diff;
  logic        dec_ge;
  logic [3:0]  shift_digit;

  logic        emit_ok;
  logic        emit_req;
  logic        emit_fire;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic        advance;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // shared subtract-and-compare unit
  assign pow      = dec_power(pow_idx);
  assign sub_diff = {1'b0, mag} - {1'b0, pow};
  assign dec_ge   = !sub_diff[32];

  assign shift_digit = is_hex ? sreg[32:29] : {1'b0, sreg[32:30]};

  // output register is free when empty or being drained this cycle
  assign emit_ok   = !out_valid || out_ready;
  assign emit_fire = emit_req && emit_ok;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (value == 32'd0) begin
            state_next = S_ZERO;
          end else if (operation == OP_SDEC && value[31]) begin
            state_next = S_SIGN;
          end else if (operation == OP_SDEC || operation == OP_UDEC) begin
            state_next = S_DEC;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_ZERO: begin
        if (advance) state_next = S_IDLE;
      end
      S_SIGN: begin
        if (advance) state_next = S_DEC;
      end
      S_DEC: begin
        if (advance && !dec_ge && pow_idx == LAST_POW) state_next = S_IDLE;
      end
      S_SHIFT: begin
        if (advance && cnt == 4'd1) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // step control: what to emit and whether the sequencer may move on
  always_comb begin
    emit_req  = 1'b0;
    emit_char = CHAR_ZERO;
    emit_last = 1'b0;
    advance   = 1'b0;
    unique case (state)
      S_IDLE: begin
        advance = 1'b0;
      end
      S_ZERO: begin
        emit_req  = 1'b1;
        emit_last = 1'b1;
        advance   = emit_ok;
      end
      S_SIGN: begin
        emit_req  = 1'b1;
        emit_char = CHAR_MINUS;
        advance   = emit_ok;
      end
      S_DEC: begin
        if (dec_ge) begin
          // keep subtracting this power of ten
          advance = 1'b1;
        end else begin
          // place finished: emit unless it is a leading zero
          emit_req  = (digit != 4'd0) || started;
          emit_char = digit_char(digit);
          emit_last = (pow_idx == LAST_POW);
          advance   = !emit_req || emit_ok;
        end
      end
      S_SHIFT: begin
        emit_req  = (shift_digit != 4'd0) || started;
        emit_char = digit_char(shift_digit);
        emit_last = (cnt == 4'd1);
        advance   = !emit_req || emit_ok;
      end
      default: begin
        advance = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload: hold until the next character is loaded
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      character <= emit_char;
      last      <= emit_last;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      // take the magnitude of negative signed values up front
      if (operation == OP_SDEC && value[31]) begin
        mag <= ~value + 32'd1;
      end else begin
        mag <= value;
      end
      digit   <= 4'd0;
      pow_idx <= 4'd0;
      started <= 1'b0;
      is_hex  <= (operation == OP_HEX);
      if (operation == OP_HEX) begin
        sreg <= {value, 1'b0};
        cnt  <= HEX_DIGITS;
      end else begin
        // octal: pad one zero on top so the first group holds the top two bits
        sreg <= {1'b0, value};
        cnt  <= OCT_DIGITS;
      end
    end else if (advance && state == S_DEC) begin
      if (dec_ge) begin
        mag   <= sub_diff[31:0];
        digit <= digit + 4'd1;
      end else begin
        digit   <= 4'd0;
        pow_idx <= pow_idx + 4'd1;
        if (emit_req) started <= 1'b1;
      end
    end else if (advance && state == S_SHIFT) begin
      if (is_hex) begin
        sreg <= {sreg[28:0], 4'b0};
      end else begin
        sreg <= {sreg[29:0], 3'b0};
      end
      cnt <= cnt - 4'd1;
      if (emit_req) started <= 1'b1;
    end
  end

  // a decimal place never collects more than nine subtractions
  `ITAR_ASSERT_IMP(a_dec_digit_range, state == S_DEC, digit <= 4'd9)
  // the ones place always produces a character, so every run gets its last flag
  `ITAR_ASSERT_IMP(a_dec_ones_emits, state == S_DEC && !dec_ge && pow_idx == LAST_POW, emit_req)
  // the final character of a run returns the sequencer to idle
  `ITAR_ASSERT_NXT(a_last_to_idle, emit_fire && emit_last, state == S_IDLE)
  // a minus sign is always followed by the decimal magnitude
  `ITAR_ASSERT_NXT(a_sign_to_dec, state == S_SIGN && advance, state == S_DEC)
  // hex/octal never runs with an empty digit count
  `ITAR_ASSERT_IMP(a_shift_cnt_live, state == S_SHIFT, cnt != 4'd0)

endmodule

FILE: tb/itoa_char_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts the character run of every accepted
// number and compares each accepted character against the oldest prediction.
module itoa_char_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  character,
  input  logic        last,
  output int          fail_count,
  output int          outstanding
);

  import itoa_pkg::*;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] digit_code(input logic [3:0] d);
    return (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_LOWER_A + 8'(d) - 8'd10;
  endfunction

  // Append the full character run of one number, last flag on its final character.
  function automatic void predict_text(input logic [1:0] op, input logic [31:0] num);
    logic [7:0]  run[$];
    logic [31:0] mag;
    logic [31:0] step;
    logic [3:0]  d;
    bit          started;
    int          s;
    text_char_t  entry;
    mag = num;
    started = 1'b0;
    if (num == 32'd0) begin
      run.push_back(CHAR_ZERO);
    end else if (op == OP_SDEC || op == OP_UDEC) begin
      if (op == OP_SDEC && num[31]) begin
        run.push_back(CHAR_MINUS);
        mag = ~num + 32'd1;
      end
      // strip powers of ten by repeated subtraction
      step = 32'd1000000000;
      for (s = 0; s < 10; s++) begin
        d = 4'd0;
        while (mag >= step) begin
          mag = mag - step;
          d++;
        end
        if (d != 4'd0 || started) begin
          run.push_back(digit_code(d));
          started = 1'b1;
        end
        step = step / 32'd10;
      end
    end else begin
      for (s = (op == OP_HEX) ? 28 : 30; s >= 0; s -= (op == OP_HEX) ? 4 : 3) begin
        d = (op == OP_HEX) ? 4'(num >> s) : {1'b0, 3'(num >> s)};
        if (d != 4'd0 || started) begin
          run.push_back(digit_code(d));
          started = 1'b1;
        end
      end
    end
    foreach (run[i]) begin
      entry.code = run[i];
      entry.fin  = (i == run.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      expected_text.delete();
      outstanding <= 0;
    end else begin
      // compare before predicting: a number taken at this edge cannot answer at this edge
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character %02h last %0b with nothing pending",
                                    character, last));
        end else begin
          want = expected_text.pop_front();
          if (character !== want.code) begin
            report_mismatch($sformatf("character %02h, expected %02h", character, want.code));
          end
          if (last !== want.fin) begin
            report_mismatch($sformatf("last %0b on character %02h, expected %0b",
                                      last, character, want.fin));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_text(operation, value);
      end
      outstanding <= expected_text.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import itoa_pkg::*;

  // Runs of numbers: a directed part, then random numbers; the final stretch runs
  // with no idling on either side.
  localparam int RANDOM_ITEMS   = 77;
  localparam int CALM_ITEMS     = 20;
  // The longest quiet spell between transactions in a correct run comes from a slow decimal
  // place plus a full output stall; allow far more.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_SDEC;
  logic [31:0] value     = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  character;
  logic        last;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;

  integer_to_ascii_radix uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  itoa_char_checker char_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .character   (character),
    .last        (last),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output back-pressure: drop ready in random bursts, hold it high
  // once the calm stretch begins.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("integer_to_ascii_radix verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one number and hold it until the converter takes it. Valid stays high
  // into the next call unless that call opens an idle gap first, so it is never
  // lowered and raised in the same step.
  task automatic send_number(input logic [1:0] op, input logic [31:0] num);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic [1:0]  op;
    logic [31:0] num;
    logic [31:0] tens;
    int          n;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero gives a lone '0' in every mode.
    send_number(OP_SDEC, 32'd0);
    send_number(OP_UDEC, 32'd0);
    send_number(OP_HEX,  32'd0);
    send_number(OP_OCT,  32'd0);
    // Signed decimal: minus one, most negative value, most positive, short runs.
    send_number(OP_SDEC, 32'hffff_ffff);
    send_number(OP_SDEC, 32'h8000_0000);
    send_number(OP_SDEC, 32'h8000_0001);
    send_number(OP_SDEC, 32'h7fff_ffff);
    send_number(OP_SDEC, 32'd1);
    // Unsigned decimal: all ones, powers of ten and their neighbors.
    send_number(OP_UDEC, 32'hffff_ffff);
    send_number(OP_UDEC, 32'd1000000000);
    send_number(OP_UDEC, 32'd999999999);
    send_number(OP_UDEC, 32'd9);
    send_number(OP_UDEC, 32'd10);
    // Hex: every letter digit, top nibble alone, single low digit.
    send_number(OP_HEX,  32'hffff_ffff);
    send_number(OP_HEX,  32'habcd_ef01);
    send_number(OP_HEX,  32'h8000_0000);
    send_number(OP_HEX,  32'h0000_000a);
    // Octal: the first digit comes from the top two bits alone.
    send_number(OP_OCT,  32'hffff_ffff);
    send_number(OP_OCT,  32'h4000_0000);
    send_number(OP_OCT,  32'hc000_0000);
    send_number(OP_OCT,  32'd7);
    send_number(OP_OCT,  32'd8);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        calm <= 1'b1;
      end
      op = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: num = 32'd0;
        1: num = $urandom_range(0, 1000);
        2: num = 32'd0 - 32'($urandom_range(1, 1000));
        3: num = $urandom >> $urandom_range(0, 31);
        4: begin
          // land on or next to a power of ten
          tens = 32'd1;
          repeat ($urandom_range(0, 9)) tens = tens * 32'd10;
          num = tens + 32'($urandom_range(0, 2)) - 32'd1;
        end
        default: num = $urandom;
      endcase
      send_number(op, num);
    end
    in_valid <= 1'b0;

    // Drain every predicted character, then watch a while for strays.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("integer_to_ascii_radix verification clean");
    end else begin
      $display("integer_to_ascii_radix verification failed");
    end
    $finish;
  end

endmodule
